FILE: hdl/cmbc_pkg.sv
// ---------------------------------------------------------------------------
// cmbc_pkg: shared types and constants
// Column min/max template band check: field widths, codes, memory layout.
// ---------------------------------------------------------------------------
package cmbc_pkg;

    localparam int IMAGE_WIDTH = 4096;
    localparam int ADDR_W      = (IMAGE_WIDTH > 1) ? $clog2(IMAGE_WIDTH) : 1;

    localparam int MODE_W   = 2;
    localparam int COL_W    = 12;
    localparam int PIX_W    = 8;
    localparam int DEV_W    = 9;
    localparam int MARGIN_W = 7;
    localparam int EPOCH_W  = 8;

    localparam logic [PIX_W-1:0]    PIX_MAX    = 8'hff;
    localparam logic [MARGIN_W-1:0] MARGIN_MIN = 7'd10;
    localparam logic [MARGIN_W-1:0] MARGIN_MAX = 7'd110;

    typedef enum logic [MODE_W-1:0] {
        MODE_CHECK  = 2'd0,
        MODE_TRAIN  = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_UNUSED = 2'd3
    } t_mode;

    typedef enum logic {
        CFG_LOW_MARGIN  = 1'b0,
        CFG_HIGH_MARGIN = 1'b1
    } t_cfg_idx;

    // tag == current epoch means the column is trained; tag 0 is never current
    typedef struct packed {
        logic [EPOCH_W-1:0] tag;
        logic [PIX_W-1:0]   mn;
        logic [PIX_W-1:0]   mx;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

FILE: hdl/cmbc_in_if.sv
// ---------------------------------------------------------------------------
// cmbc_in_if: pixel item channel
// Valid/ready channel carrying mode, column and pixel.
// ---------------------------------------------------------------------------
interface cmbc_in_if;
    import cmbc_pkg::*;

    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [COL_W-1:0]   column;
    logic [PIX_W-1:0]   pixel;

    modport source (output valid, output mode, output column, output pixel, input ready);
    modport sink   (input valid, input mode, input column, input pixel, output ready);
endinterface

FILE: hdl/cmbc_out_if.sv
// ---------------------------------------------------------------------------
// cmbc_out_if: result item channel
// Valid/ready channel carrying the deviation and the checked column.
// ---------------------------------------------------------------------------
interface cmbc_out_if;
    import cmbc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DEV_W-1:0]  deviation;
    logic [COL_W-1:0]         out_column;

    modport source (output valid, output deviation, output out_column, input ready);
    modport sink   (input valid, input deviation, input out_column, output ready);
endinterface

FILE: hdl/column_minmax_band_check.sv
// ---------------------------------------------------------------------------
// column_minmax_band_check: per-column min/max template with band check
// Keeps a min/max per column in one RAM and checks pixels against the band.
// ---------------------------------------------------------------------------
// Usage:
//   i_px carries items (mode, column, pixel). Train folds the pixel into the
//   column's min/max, clear forgets all columns, check returns one result
//   item on o_res (deviation, out_column). Train, clear and mode 3 give none.
//   Margins must be written on i_cfg_* only while no item is in flight; the
//   block does not enforce this. Written values are clamped to 10..110.
// Throughput: one item per cycle unless o_res is held or a sweep runs. The
//   column RAM is read when an item is accepted and written back when it
//   leaves the compute stage; a one-entry write-forward covers back-to-back
//   items on the same column. Check results then enter the output register.
// Clear bumps an epoch counter instead of touching the RAM. After reset, and
//   after every 255th clear when the epoch wraps, a sweep writes all
//   IMAGE_WIDTH entries with i_px.ready low.
// Stall: when o_res is held, the output register and the compute stage hold
//   and i_px.ready drops in the same cycle.
// ---------------------------------------------------------------------------
module column_minmax_band_check (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    cmbc_in_if.sink                       i_px,
    cmbc_out_if.source                    o_res,
    input  logic                          i_cfg_we,
    input  cmbc_pkg::t_cfg_idx            i_cfg_idx,
    input  logic [cmbc_pkg::MARGIN_W-1:0] i_cfg_data
);
    import cmbc_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(IMAGE_WIDTH - 1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;

    // control
    logic                r_clearing;
    logic [ADDR_W-1:0]   r_clr_addr;
    logic [EPOCH_W-1:0]  r_epoch;
    logic [MARGIN_W-1:0] r_low_margin;
    logic [MARGIN_W-1:0] r_high_margin;

    // compute stage
    logic                r_s1_vld;
    t_mode               r_s1_mode;
    logic [COL_W-1:0]    r_s1_col;
    logic [ADDR_W-1:0]   r_s1_addr;
    logic                r_s1_inside;
    logic [PIX_W-1:0]    r_s1_pix;
    logic [EPOCH_W-1:0]  r_s1_epoch;

    // last write, for forwarding
    logic                r_wr_vld;
    logic [ADDR_W-1:0]   r_wr_addr;
    t_entry              r_wr_data;

    // output register
    logic                    r_out_vld;
    logic signed [DEV_W-1:0] r_out_dev;
    logic [COL_W-1:0]        r_out_col;

    logic adv;
    logic accept;
    logic in_inside;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    t_entry              ram_wdata;
    t_entry              ram_rdata;

    t_entry              ent;
    logic                trained;
    logic [PIX_W-1:0]    mn;
    logic [PIX_W-1:0]    mx;
    t_entry              s1_new;
    logic                s1_we;
    logic                s1_check;
    logic [PIX_W-1:0]    low;
    logic [PIX_W:0]      high_sum;
    logic [PIX_W-1:0]    high;
    logic signed [DEV_W-1:0] n_out_dev;
    logic [EPOCH_W-1:0]  n_epoch;
    logic                n_clearing;

    function automatic logic [MARGIN_W-1:0] clamp_margin(input logic [MARGIN_W-1:0] v);
        logic [MARGIN_W-1:0] m;
        m = v;
        if (m < MARGIN_MIN) m = MARGIN_MIN;
        if (m > MARGIN_MAX) m = MARGIN_MAX;
        return m;
    endfunction

    assign adv        = !r_out_vld || o_res.ready;
    assign i_px.ready = adv && !r_clearing;
    assign accept     = i_px.valid && i_px.ready;
    assign in_inside  = 32'(i_px.column) < 32'(IMAGE_WIDTH);

    assign o_res.valid      = r_out_vld;
    assign o_res.deviation  = r_out_dev;
    assign o_res.out_column = r_out_col;

    cmbc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (IMAGE_WIDTH)
    ) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (adv),
        .i_raddr (ADDR_W'(i_px.column)),
        .o_rdata (ram_rdata)
    );

    // read-modify-write of the column entry and band check of the pixel
    always_comb begin
        ent = (r_wr_vld && r_wr_addr == r_s1_addr) ? r_wr_data : ram_rdata;
        trained = r_s1_inside && ent.tag == r_s1_epoch;
        mn = trained ? ent.mn : PIX_MAX;
        mx = trained ? ent.mx : '0;

        s1_new.tag = r_s1_epoch;
        if (!trained) begin
            s1_new.mn = r_s1_pix;
            s1_new.mx = r_s1_pix;
        end else begin
            s1_new.mn = (r_s1_pix < ent.mn) ? r_s1_pix : ent.mn;
            s1_new.mx = (r_s1_pix > ent.mx) ? r_s1_pix : ent.mx;
        end
        s1_we    = r_s1_vld && r_s1_mode == MODE_TRAIN && r_s1_inside && adv;
        s1_check = r_s1_vld && r_s1_mode == MODE_CHECK;

        low      = (mn > {1'b0, r_low_margin}) ? mn - {1'b0, r_low_margin} : '0;
        high_sum = {1'b0, mx} + {2'b0, r_high_margin};
        high     = high_sum[PIX_W] ? PIX_MAX : high_sum[PIX_W-1:0];
        if (r_s1_pix < low) begin
            n_out_dev = $signed({1'b0, r_s1_pix}) - $signed({1'b0, low});
        end else if (r_s1_pix > high) begin
            n_out_dev = $signed({1'b0, r_s1_pix}) - $signed({1'b0, high});
        end else begin
            n_out_dev = '0;
        end
    end

    // sweep owns the write port; no train item is in flight while it runs
    always_comb begin
        if (r_clearing) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = s1_we;
            ram_waddr = r_s1_addr;
            ram_wdata = s1_new;
        end
    end

    always_comb begin
        n_epoch    = r_epoch;
        n_clearing = r_clearing;
        if (r_clearing && r_clr_addr == LAST_ADDR) begin
            n_clearing = 1'b0;
        end
        if (accept && i_px.mode == MODE_CLEAR) begin
            if (r_epoch == EPOCH_LAST) begin
                n_epoch    = EPOCH_W'(1);
                n_clearing = 1'b1;
            end else begin
                n_epoch = r_epoch + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing    <= 1'b1;
            r_clr_addr    <= '0;
            r_epoch       <= EPOCH_W'(1);
            r_low_margin  <= MARGIN_MIN;
            r_high_margin <= MARGIN_MIN;
            r_s1_vld      <= 1'b0;
            r_wr_vld      <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            r_clearing <= n_clearing;
            r_epoch    <= n_epoch;
            r_clr_addr <= r_clearing ? r_clr_addr + 1'b1 : '0;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LOW_MARGIN:  r_low_margin  <= clamp_margin(i_cfg_data);
                    CFG_HIGH_MARGIN: r_high_margin <= clamp_margin(i_cfg_data);
                    default: ;
                endcase
            end

            if (r_clearing) begin
                r_wr_vld <= 1'b0;
            end else if (adv) begin
                r_wr_vld <= s1_we;
            end

            if (adv) begin
                r_s1_vld  <= accept;
                r_out_vld <= s1_check;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_mode   <= t_mode'(i_px.mode);
            r_s1_col    <= i_px.column;
            r_s1_addr   <= ADDR_W'(i_px.column);
            r_s1_inside <= in_inside;
            r_s1_pix    <= i_px.pixel;
            r_s1_epoch  <= r_epoch;
            r_wr_addr   <= r_s1_addr;
            r_wr_data   <= s1_new;
            if (s1_check) begin
                r_out_dev <= n_out_dev;
                r_out_col <= r_s1_col;
            end
        end
    end

    // assertions
    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !accept)
        else $error("item accepted during memory sweep");

    a_no_fwd_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |=> !r_wr_vld)
        else $error("forward entry live during memory sweep");

    a_check_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_check && adv) |=> r_out_vld)
        else $error("check item left compute stage without a result");

    a_epoch_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_epoch != '0)
        else $error("epoch reached the swept tag value");

    a_train_not_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !s1_we)
        else $error("train write collides with memory sweep");

endmodule

FILE: hdl/cmbc_ram.sv
// ---------------------------------------------------------------------------
// cmbc_ram: generic simple dual-port RAM
// One write port, one read port with registered read data (read-first).
// ---------------------------------------------------------------------------
module cmbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
